// ===== hdl/hbs_pkg.sv =====
// Shared types and constants for the bucketed hash set.
// Holds the item and result structs, status codes and the controller states.
// No dependencies.
`timescale 1ns / 1ps

package hbs_pkg;

	localparam int HBS_BUCKETS  = 7;
	localparam int HBS_SLOTS    = 4;
	localparam int HBS_KEY_BITS = 16;

	// Fixed widths of the item and result fields.
	localparam int KEY_W    = 16;
	localparam int STATUS_W = 3;
	localparam int BUCKET_W = 3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_PRESENT   = 3'd1,
		STAT_FOUND     = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		status_t             status;
		logic [BUCKET_W-1:0] bucket;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_HASH,
		ST_UPDATE
	} state_t;

endpackage

// ===== hdl/hbs_mod.sv =====
// Three-stage pipeline that reduces a key modulo the bucket count.
// Uses a reciprocal multiply, a back-multiply and one correction step.
// Depends on hbs_pkg.
`timescale 1ns / 1ps

module hbs_mod #(
	parameter int BUCKETS  = 7,
	parameter int KW       = 16,
	parameter int BIW      = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [KW-1:0]  key,
	output logic           out_valid,
	output logic [BIW-1:0] bucket
);
	import hbs_pkg::*;

	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
	localparam int SHIFT = KW + BW;
	localparam int MW    = SHIFT + 1;
	localparam int PW    = KW + MW;
	localparam int EW    = KW + BIW + 1;
	localparam longint unsigned RECIP = (64'd1 << SHIFT) / BUCKETS;

	logic [PW-1:0] prod_s1;
	logic [KW-1:0] key_s1;
	logic [EW-1:0] qb_s2;
	logic [KW-1:0] key_s2;
	logic [KW-1:0] quot;
	logic [EW-1:0] rem_w;
	logic [EW-1:0] rem_c;
	logic          valid_s1, valid_s2, valid_s3;
	logic [BIW-1:0] bucket_s3;

	// The estimated quotient is the true one or one less, so the remainder
	// stays below twice the bucket count and one subtraction corrects it.
	assign quot  = prod_s1[SHIFT +: KW];
	assign rem_w = EW'(key_s2) - qb_s2;
	assign rem_c = (rem_w >= EW'(BUCKETS)) ? (rem_w - EW'(BUCKETS)) : rem_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		key_s1    <= key;
		prod_s1   <= PW'(key) * PW'(RECIP);
		key_s2    <= key_s1;
		qb_s2     <= EW'(quot) * EW'(BUCKETS);
		bucket_s3 <= rem_c[BIW-1:0];
	end

	assign out_valid = valid_s3;
	assign bucket    = bucket_s3;

endmodule

// ===== hdl/hbs_ram.sv =====
// Single-port-write, single-port-read synchronous memory, one bucket row per entry.
// Read data is registered and appears in the cycle after the address. Depends on hbs_pkg.
`timescale 1ns / 1ps

module hbs_ram #(
	parameter int DEPTH = 7,
	parameter int WIDTH = 68,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import hbs_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/bucketed_hash_set_insert_search.sv =====
// Top level of the bucketed hash set: controller, compare and update logic.
// Instantiates hbs_mod and hbs_ram; depends on hbs_pkg.
//
// Usage: an item (action, key) is taken at a rising edge where start is high
// and busy is low. The bucket is the key modulo BUCKETS. An insert reports a
// duplicate, appends the key to its bucket, or reports the bucket full and
// drops the key. A search reports found or not found.
// Each item gives exactly one result, shown on result for one cycle while
// done is high. The receiver cannot stall, so nothing is ever held back.
// The result is registered after the modulo pipeline, the memory read and
// the compare and write-back. Busy falls with done, so the next item can be
// taken at the edge that ends the done cycle. No new item is taken before
// the last one's result is out: the modulo pipeline and the read-modify-write
// of the bucket row in the row memory hold busy high until then.
// Each memory row holds all slots of one bucket plus its fill count.
// After reset the block runs a clearing pass that zeroes every row, one row
// a cycle, from row 0 up to row BUCKETS-1; busy stays high until it is done.
// Only one item is in flight, so a bucket write always lands before the
// next item reads any row.
`timescale 1ns / 1ps

module bucketed_hash_set_insert_search #(
	parameter int BUCKETS          = hbs_pkg::HBS_BUCKETS,
	parameter int SLOTS_PER_BUCKET = hbs_pkg::HBS_SLOTS,
	parameter int KEY_BITS         = hbs_pkg::HBS_KEY_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  hbs_pkg::item_t   item,
	output logic             done,
	output hbs_pkg::result_t result
);
	import hbs_pkg::*;

	// Keys arrive 16 bits wide, so at most 16 bits are ever stored.
	localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW  = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int RW  = SLOTS_PER_BUCKET * KW + FW;

	state_t         state_q, state_d;
	logic [BIW-1:0] clr_cnt_q;
	logic           clr_last;
	logic           accept;

	logic           action_q;
	logic [KW-1:0]  key_q;
	logic [BIW-1:0] bucket_q;
	logic           done_q;
	result_t        result_q;

	logic           mod_valid;
	logic [BIW-1:0] mod_bucket;

	logic           ram_we;
	logic [BIW-1:0] ram_waddr;
	logic [RW-1:0]  ram_wdata;
	logic [BIW-1:0] ram_raddr;
	logic [RW-1:0]  rd_row;

	logic [FW-1:0]  rd_fill;
	logic           hit;
	logic           do_insert;
	status_t        status_d;
	logic [RW-1:0]  new_row;
	logic [BIW+2:0] bucket_ext;

	assign accept = start && !busy;

	hbs_mod #(
		.BUCKETS (BUCKETS),
		.KW      (KW),
		.BIW     (BIW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.key       (item.key[KW-1:0]),
		.out_valid (mod_valid),
		.bucket    (mod_bucket)
	);

	hbs_ram #(
		.DEPTH (BUCKETS),
		.WIDTH (RW),
		.AW    (BIW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_row)
	);

	// The fill count sits above the slots; slots at or past it are stale.
	assign rd_fill  = rd_row[RW-1 -: FW];
	assign clr_last = (clr_cnt_q == BIW'(BUCKETS - 1));

	always_comb begin
		hit     = 1'b0;
		new_row = rd_row;
		for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
			if ((FW'(s) < rd_fill) && (rd_row[s*KW +: KW] == key_q)) begin
				hit = 1'b1;
			end
			if (FW'(s) == rd_fill) begin
				new_row[s*KW +: KW] = key_q;
			end
		end
		new_row[RW-1 -: FW] = rd_fill + FW'(1);
	end

	always_comb begin
		do_insert = 1'b0;
		if (action_q == ACT_INSERT) begin
			if (hit) begin
				status_d = STAT_PRESENT;
			end else if (rd_fill >= FW'(SLOTS_PER_BUCKET)) begin
				status_d = STAT_FULL;
			end else begin
				status_d  = STAT_INSERTED;
				do_insert = 1'b1;
			end
		end else begin
			status_d = hit ? STAT_FOUND : STAT_NOT_FOUND;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_HASH;
			ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
			ST_HASH:   if (mod_valid) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Controller outputs: memory port control and busy.
	always_comb begin
		busy      = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = bucket_q;
		ram_wdata = new_row;
		ram_raddr = mod_bucket;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			ST_UPDATE: begin
				ram_we = do_insert;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPDATE);
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + BIW'(1);
			end
		end
	end

	assign bucket_ext = {3'b000, bucket_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= item.action;
			key_q    <= item.key[KW-1:0];
		end
		if (mod_valid) begin
			bucket_q <= mod_bucket;
		end
		if (state_q == ST_UPDATE) begin
			result_q.status <= status_d;
			result_q.bucket <= bucket_ext[BUCKET_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result only follows an update cycle.
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without an update cycle");

	// The modulo pipeline only delivers while the controller waits for it.
	a_mod_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		mod_valid |-> (state_q == ST_HASH))
		else $error("bucket index arrived outside the hash state");

	// The reduced key always addresses an existing bucket.
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		mod_valid |-> ({1'b0, mod_bucket} < (BIW+1)'(BUCKETS)))
		else $error("bucket index out of range");

	// A bucket never holds more keys than it has slots.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (rd_fill <= FW'(SLOTS_PER_BUCKET)))
		else $error("fill count exceeds slot count");

	// No item is accepted while the clearing pass runs.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> busy)
		else $error("block idle during clearing pass");

endmodule

// ===== test/bucketed_hash_set_insert_search_tb.sv =====
// Self-checking testbench for the bucketed hash set (insert and search of keys).
// Drives items through start/busy and checks every done strobe against a shadow hash set.
// Depends on hbs_pkg and the bucketed_hash_set_insert_search top level.
`timescale 1ns / 1ps

module bucketed_hash_set_insert_search_tb;

	import hbs_pkg::*;

	// The run is stopped here if the block hangs. A correct run needs
	// well under a tenth of this.
	localparam int TIMEOUT_NS = 400000;

	// Number of random items after the directed part.
	localparam int RANDOM_ITEMS = 730;

	// Keys drawn from this pool repeat often, so that duplicates, hits
	// and full buckets are common.
	localparam int POOL_SIZE = 48;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	// Items that wait for the driver. The head is the item on the ports,
	// or the next one to go out while start is low.
	item_t   pending_items[$];
	// Outcomes that the shadow hash set predicts, oldest first.
	result_t expected_results[$];

	// Shadow copy of the bucket contents and fill counts.
	logic [KEY_W-1:0] shadow_keys[HBS_BUCKETS][HBS_SLOTS];
	int               shadow_fill[HBS_BUCKETS];

	int mismatch_count = 0;

	bucketed_hash_set_insert_search DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	// Applies one accepted item to the shadow hash set and returns the
	// result that the block has to report for it.
	function automatic result_t hash_set_outcome(item_t it);
		result_t          res;
		logic [KEY_W-1:0] k;
		int               b;
		int               fill;
		bit               hit;
		k    = it.key & KEY_W'((64'd1 << HBS_KEY_BITS) - 1);
		b    = int'(k) % HBS_BUCKETS;
		fill = (shadow_fill[b] > HBS_SLOTS) ? HBS_SLOTS : shadow_fill[b];
		hit  = 1'b0;
		// Only occupied slots are compared, so slots that were never
		// written cannot produce a false hit.
		for (int s = 0; s < fill; s++) begin
			if (shadow_keys[b][s] == k)
				hit = 1'b1;
		end
		if (it.action == ACT_INSERT) begin
			if (hit) begin
				// A duplicate is reported even when the bucket is full.
				res.status = STAT_PRESENT;
			end else if (shadow_fill[b] >= HBS_SLOTS) begin
				// No free slot: the key is dropped and nothing changes.
				res.status = STAT_FULL;
			end else begin
				shadow_keys[b][shadow_fill[b]] = k;
				shadow_fill[b]++;
				res.status = STAT_INSERTED;
			end
		end else begin
			res.status = hit ? STAT_FOUND : STAT_NOT_FOUND;
		end
		res.bucket = BUCKET_W'(b);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Most gaps are short, a few are long.
	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	// Driver. The item on the ports is taken at an edge where start is
	// high and busy is low; from that edge on the shadow state is updated.
	// Start is assigned once per edge, so a back-to-back item keeps start
	// high without a glitch. The driver switches now and then between a
	// calm stretch with no gaps and a stretch with random gaps.
	int idle_left   = 0;
	int mode_left   = 40;
	bit gap_free    = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(hash_set_outcome(pending_items.pop_front()));
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					start <= 1'b1;
					item  <= pending_items[0];
					if (mode_left == 0) begin
						gap_free  = ($urandom_range(0, 2) == 0);
						mode_left = $urandom_range(20, 60);
					end else begin
						mode_left--;
					end
					idle_left = gap_free ? 0 : draw_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. A result is valid for the single cycle in which done is
	// high and is compared with the oldest prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected, status", result.status, -1);
			end else begin
				if (result.status !== expected_results[0].status)
					report_mismatch("status", result.status, expected_results[0].status);
				if (result.bucket !== expected_results[0].bucket)
					report_mismatch("bucket", result.bucket, expected_results[0].bucket);
				void'(expected_results.pop_front());
			end
		end
	end

	// Appends one item to the driver's queue.
	task automatic queue_item(input logic act, input logic [KEY_W-1:0] k);
		item_t it;
		it.action = act;
		it.key    = k;
		pending_items.push_back(it);
	endtask

	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	initial begin
		int roll;
		logic [KEY_W-1:0] k;

		for (int b = 0; b < HBS_BUCKETS; b++)
			shadow_fill[b] = 0;

		// Directed part: the key extremes, both actions, a duplicate, a
		// bucket filled to the last slot, an insert dropped in a full
		// bucket, a duplicate in a full bucket and searches in it.
		queue_item(ACT_SEARCH, 16'd0);
		queue_item(ACT_INSERT, 16'd0);
		queue_item(ACT_SEARCH, 16'd0);
		queue_item(ACT_INSERT, 16'd0);
		queue_item(ACT_SEARCH, 16'hFFFF);
		queue_item(ACT_INSERT, 16'hFFFF);
		queue_item(ACT_SEARCH, 16'hFFFF);
		queue_item(ACT_INSERT, 16'hFFFF);
		queue_item(ACT_INSERT, 16'd7);
		queue_item(ACT_INSERT, 16'd14);
		queue_item(ACT_INSERT, 16'd21);
		queue_item(ACT_INSERT, 16'd28);
		queue_item(ACT_INSERT, 16'd7);
		queue_item(ACT_INSERT, 16'd0);
		queue_item(ACT_SEARCH, 16'd21);
		queue_item(ACT_SEARCH, 16'd28);
		queue_item(ACT_INSERT, 16'd6);
		queue_item(ACT_SEARCH, 16'd6);
		queue_item(ACT_INSERT, 16'h8000);
		queue_item(ACT_SEARCH, 16'h8000);
		queue_item(ACT_SEARCH, 16'h7FFF);

		// Random part. Most items use keys from the pool, so buckets fill
		// up and lookups hit; the rest are keys from the whole range.
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom_range(0, 16'hFFFF));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 75)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = KEY_W'($urandom_range(0, 16'hFFFF));
			queue_item(logic'($urandom_range(0, 1)), k);
		end

		// Reset is applied once, from the start of the run.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// The block first runs its clearing pass with busy high; the
		// driver simply waits for busy to fall.
		while (pending_items.size() != 0)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// A few more cycles to catch any stray done strobe.
		repeat (12) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/hbs_pkg.sv
hdl/hbs_mod.sv
hdl/hbs_ram.sv
hdl/bucketed_hash_set_insert_search.sv
test/bucketed_hash_set_insert_search_tb.sv
